[rtl/pfrt_pkg.sv]
// Shared constants, codes and types of the frame reassembly slot tracker.
package pfrt_pkg;

    localparam int SLOTS         = 8;
    localparam int MAX_PACKETS   = 1024;
    localparam int SLOT_W        = 3;
    localparam int IDX_W         = 10;
    localparam int TOTAL_W       = 11;
    localparam int ROW_W         = 32;
    localparam int BIT_W         = $clog2(ROW_W);
    localparam int ROWS_PER_SLOT = MAX_PACKETS / ROW_W;
    localparam int ROW_SEL_W     = IDX_W - BIT_W;
    localparam int ADDR_W        = SLOT_W + ROW_SEL_W;
    localparam int ROWS          = SLOTS * ROWS_PER_SLOT;
    localparam int PROD_W        = IDX_W + 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] TIMEOUT_RST     = 16'd100;
    localparam logic [7:0]  HEADER_RST      = 8'd16;
    localparam logic [7:0]  META_RST        = 8'd12;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1400;

    typedef enum logic [3:0] {
        ST_PARTIAL    = 4'd0,
        ST_COMPLETE   = 4'd1,
        ST_TIMEOUT    = 4'd2,
        ST_SHORT      = 4'd3,
        ST_BAD_HDR    = 4'd4,
        ST_DUP        = 4'd5,
        ST_META_SHORT = 4'd6,
        ST_NO_META    = 4'd7,
        ST_PURGE      = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        K_PACKET,
        K_PURGE,
        K_SHORT,
        K_BAD
    } kind_t;

    typedef enum logic [1:0] {
        CFG_TIMEOUT     = 2'd0,
        CFG_HEADER      = 2'd1,
        CFG_META        = 2'd2,
        CFG_MAX_PAYLOAD = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_ALLOC,
        S_RD,
        S_EXEC
    } back_state_t;

    typedef struct packed {
        logic [15:0] timeout_ms;
        logic [7:0]  header_bytes;
        logic [7:0]  meta_bytes;
        logic [15:0] max_payload_bytes;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [31:0]        frame_id;
        logic [TOTAL_W-1:0] packet_total;
        logic [IDX_W-1:0]   packet_index;
        logic [15:0]        payload;
        logic [15:0]        meta_width;
        logic [15:0]        meta_height;
        logic [31:0]        meta_frame_bytes;
        logic [31:0]        now_ms;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        status_t     status;
        logic [2:0]  slot_number;
        logic [31:0] write_offset;
        logic [15:0] write_length;
        logic [15:0] frame_width;
        logic [15:0] frame_height;
        logic [31:0] frame_bytes;
        logic [3:0]  purged_count;
    } result_t;

endpackage

[rtl/pfrt_queue.sv]
// Short queue of classified requests between front and back.
module pfrt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pfrt_pkg::item_t push_item,
    input  logic            pop,
    output pfrt_pkg::item_t head,
    output pfrt_pkg::q_stat_t stat
);
    import pfrt_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/pfrt_front.sv]
// Front end: accepts request beats, screens headers and queues them.
module pfrt_front (
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        req_type,
    input  logic [31:0]                 frame_id,
    input  logic [pfrt_pkg::TOTAL_W-1:0] packet_total,
    input  logic [pfrt_pkg::IDX_W-1:0]  packet_index,
    input  logic [15:0]                 raw_length,
    input  logic [15:0]                 meta_width,
    input  logic [15:0]                 meta_height,
    input  logic [31:0]                 meta_frame_bytes,
    input  logic [31:0]                 now_ms,
    input  logic [7:0]                  header_bytes,
    input  pfrt_pkg::q_stat_t           q_stat,
    output logic                        push,
    output pfrt_pkg::item_t             push_item
);
    import pfrt_pkg::*;

    kind_t kind;

    always_comb
    begin
        if (req_type)
        begin
            kind = K_PURGE;
        end
        else if (raw_length < {8'd0, header_bytes})
        begin
            kind = K_SHORT;
        end
        else if (frame_id == '0 || packet_total == '0 ||
                 packet_total > TOTAL_W'(MAX_PACKETS) ||
                 {1'b0, packet_index} >= packet_total)
        begin
            kind = K_BAD;
        end
        else
        begin
            kind = K_PACKET;
        end
    end

    assign in_ready = !q_stat.full;
    assign push     = in_valid && !q_stat.full;

    always_comb
    begin
        push_item.kind             = kind;
        push_item.frame_id         = frame_id;
        push_item.packet_total     = packet_total;
        push_item.packet_index     = packet_index;
        push_item.payload          = raw_length - {8'd0, header_bytes};
        push_item.meta_width       = meta_width;
        push_item.meta_height      = meta_height;
        push_item.meta_frame_bytes = meta_frame_bytes;
        push_item.now_ms           = now_ms;
    end

endmodule

[rtl/pfrt_back.sv]
// Back end: slot table, received bitmap memory and result register.
module pfrt_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pfrt_pkg::cfg_t    cfg,
    input  pfrt_pkg::item_t   head,
    input  pfrt_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output pfrt_pkg::result_t out_res
);
    import pfrt_pkg::*;

    back_state_t state_reg, state_next;
    item_t       item_reg;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] scan_cnt_reg;
    logic [31:0]       best_age_reg;

    logic [31:0]        frame_reg [SLOTS];
    logic [TOTAL_W-1:0] total_reg [SLOTS];
    logic [TOTAL_W-1:0] count_reg [SLOTS];
    logic [31:0]        size_reg  [SLOTS];
    logic [31:0]        start_reg [SLOTS];
    logic [31:0]        dims_reg  [SLOTS];
    logic [SLOTS-1:0]   done_reg;
    logic [SLOTS-1:0]   meta_reg;
    logic [SLOTS-1:0][ROWS_PER_SLOT-1:0] row_valid_reg;

    logic [ROW_W-1:0]  mem [ROWS];
    logic [ROW_W-1:0]  rdata_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              timed_out_reg;

    result_t out_reg, res;
    logic    out_valid_reg;

    logic              out_free, load_out;
    logic [SLOTS-1:0]  hit_vec, free_vec, exp_vec;
    logic              hit_any, free_any;
    logic [SLOT_W-1:0] hit_idx, free_idx;
    logic [SLOT_W-1:0] rd_slot;
    logic [31:0]       age;
    logic              take;

    logic [ROW_SEL_W-1:0] row_sel;
    logic [BIT_W-1:0]     bit_pos;
    logic [ADDR_W-1:0]    addr;
    logic                 row_ok, seen;
    logic                 exec_ok, exec_done, commit;
    logic [15:0]          pix, len0, len1;
    logic [PROD_W-1:0]    off;
    logic [31:0]          room, new_size, new_dims;
    logic [TOTAL_W-1:0]   count_inc;

    assign out_free = !out_valid_reg || out_ready;

    // per-slot compares, all in parallel
    always_comb
    begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            hit_vec[s]  = (frame_reg[s] == item_reg.frame_id);
            free_vec[s] = (frame_reg[s] == '0) || done_reg[s];
            exp_vec[s]  = (frame_reg[s] != '0) && !done_reg[s] &&
                          ((head.now_ms - start_reg[s]) > {16'd0, cfg.timeout_ms});
            if (hit_vec[s])
            begin
                hit_any = 1'b1;
                hit_idx = SLOT_W'(s);
            end
            if (free_vec[s])
            begin
                free_any = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    assign rd_slot = (state_reg == S_SCAN) ? scan_cnt_reg : slot_reg;
    assign age     = item_reg.now_ms - start_reg[rd_slot];
    assign take    = (scan_cnt_reg == '0) || (age > best_age_reg);

    assign row_sel = item_reg.packet_index[IDX_W-1:BIT_W];
    assign bit_pos = item_reg.packet_index[BIT_W-1:0];
    assign addr    = {slot_reg, row_sel};
    assign row_ok  = row_valid_reg[slot_reg][row_sel];
    assign seen    = row_ok && rdata_reg[bit_pos];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty && head.kind == K_PACKET)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (hit_any || free_any)
                begin
                    state_next = hit_any ? S_RD : S_ALLOC;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_cnt_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = S_ALLOC;
                end
            end
            S_ALLOC: state_next = S_RD;
            S_RD:    state_next = S_EXEC;
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        slot_next = slot_reg;
        if (state_reg == S_LOOK)
        begin
            slot_next = hit_any ? hit_idx : free_idx;
        end
        else if (state_reg == S_SCAN && take)
        begin
            slot_next = scan_cnt_reg;
        end
    end

    // queue pop, and result and control for the closing cycle of each request
    always_comb
    begin
        pop       = 1'b0;
        load_out  = 1'b0;
        exec_ok   = 1'b0;
        exec_done = 1'b0;
        count_inc = count_reg[slot_reg] + 1'b1;
        pix       = item_reg.payload - {8'd0, cfg.meta_bytes};
        len0      = ({16'd0, pix} < item_reg.meta_frame_bytes) ? pix
                                                             : item_reg.meta_frame_bytes[15:0];
        off       = prod_reg - PROD_W'(cfg.meta_bytes);
        room      = size_reg[slot_reg] - 32'(off);
        len1      = ({16'd0, item_reg.payload} < room) ? item_reg.payload : room[15:0];
        new_size  = (item_reg.packet_index == '0) ? item_reg.meta_frame_bytes
                                                  : size_reg[slot_reg];
        new_dims  = (item_reg.packet_index == '0) ?
                    {item_reg.meta_width, item_reg.meta_height} : dims_reg[slot_reg];
        res       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty && (head.kind == K_PACKET || out_free))
                begin
                    pop = 1'b1;
                end
                if (!q_stat.empty && head.kind != K_PACKET && out_free)
                begin
                    load_out = 1'b1;
                    case (head.kind)
                        K_PURGE:
                        begin
                            res.status       = ST_PURGE;
                            res.purged_count = 4'($countones(exp_vec));
                        end
                        K_SHORT: res.status = ST_SHORT;
                        default: res.status = ST_BAD_HDR;
                    endcase
                end
            end
            S_EXEC:
            begin
                load_out        = out_free;
                res.slot_number = 3'(slot_reg);
                if ({1'b0, item_reg.packet_index} >= total_reg[slot_reg])
                begin
                    res.status = ST_BAD_HDR;
                end
                else if (seen)
                begin
                    res.status = ST_DUP;
                end
                else if (item_reg.packet_index == '0)
                begin
                    if (item_reg.payload < {8'd0, cfg.meta_bytes})
                    begin
                        res.status = ST_META_SHORT;
                    end
                    else
                    begin
                        exec_ok          = 1'b1;
                        res.write_offset = '0;
                        res.write_length = len0;
                    end
                end
                else if (!meta_reg[slot_reg] || prod_reg < PROD_W'(cfg.meta_bytes) ||
                         32'(off) >= size_reg[slot_reg])
                begin
                    res.status = ST_NO_META;
                end
                else
                begin
                    exec_ok          = 1'b1;
                    res.write_offset = 32'(off);
                    res.write_length = len1;
                end
                if (exec_ok)
                begin
                    if (timed_out_reg)
                    begin
                        res.status       = ST_TIMEOUT;
                        res.write_offset = '0;
                        res.write_length = '0;
                    end
                    else if (count_inc == total_reg[slot_reg])
                    begin
                        exec_done        = 1'b1;
                        res.status       = ST_COMPLETE;
                        res.frame_width  = new_dims[31:16];
                        res.frame_height = new_dims[15:0];
                        res.frame_bytes  = new_size;
                    end
                    else
                    begin
                        res.status = ST_PARTIAL;
                    end
                end
            end
            default: ;
        endcase
    end

    assign commit = (state_reg == S_EXEC) && out_free && exec_ok;

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            mem[addr] <= (row_ok ? rdata_reg : '0) | (ROW_W'(1) << bit_pos);
        end
        if (state_reg == S_RD)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
        if (state_reg == S_RD)
        begin
            prod_reg      <= PROD_W'(item_reg.packet_index) * PROD_W'(cfg.max_payload_bytes);
            timed_out_reg <= age > {16'd0, cfg.timeout_ms};
        end
        if (state_reg == S_SCAN && take)
        begin
            best_age_reg <= age;
        end
        if (load_out)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slot_reg      <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
            meta_reg      <= '0;
            row_valid_reg <= '0;
            for (int s = 0; s < SLOTS; s++)
            begin
                frame_reg[s] <= '0;
                total_reg[s] <= '0;
                count_reg[s] <= '0;
                size_reg[s]  <= '0;
                start_reg[s] <= '0;
                dims_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == S_LOOK)
            begin
                scan_cnt_reg <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end

            // purge of expired incomplete slots
            if (load_out && state_reg == S_IDLE && head.kind == K_PURGE)
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    if (exp_vec[s])
                    begin
                        frame_reg[s]     <= '0;
                        total_reg[s]     <= '0;
                        count_reg[s]     <= '0;
                        size_reg[s]      <= '0;
                        start_reg[s]     <= '0;
                        dims_reg[s]      <= '0;
                        done_reg[s]      <= 1'b0;
                        meta_reg[s]      <= 1'b0;
                        row_valid_reg[s] <= '0;
                    end
                end
            end

            if (state_reg == S_ALLOC)
            begin
                frame_reg[slot_reg]     <= item_reg.frame_id;
                total_reg[slot_reg]     <= item_reg.packet_total;
                count_reg[slot_reg]     <= '0;
                size_reg[slot_reg]      <= '0;
                start_reg[slot_reg]     <= item_reg.now_ms;
                dims_reg[slot_reg]      <= '0;
                done_reg[slot_reg]      <= 1'b0;
                meta_reg[slot_reg]      <= 1'b0;
                row_valid_reg[slot_reg] <= '0;
            end

            if (commit)
            begin
                if (timed_out_reg)
                begin
                    frame_reg[slot_reg]     <= '0;
                    total_reg[slot_reg]     <= '0;
                    count_reg[slot_reg]     <= '0;
                    size_reg[slot_reg]      <= '0;
                    start_reg[slot_reg]     <= '0;
                    dims_reg[slot_reg]      <= '0;
                    done_reg[slot_reg]      <= 1'b0;
                    meta_reg[slot_reg]      <= 1'b0;
                    row_valid_reg[slot_reg] <= '0;
                end
                else
                begin
                    row_valid_reg[slot_reg][row_sel] <= 1'b1;
                    count_reg[slot_reg]              <= count_inc;
                    size_reg[slot_reg]               <= new_size;
                    dims_reg[slot_reg]               <= new_dims;
                    if (item_reg.packet_index == '0)
                    begin
                        meta_reg[slot_reg] <= 1'b1;
                    end
                    if (exec_done)
                    begin
                        done_reg[slot_reg] <= 1'b1;
                    end
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

`ifndef SYNTH
    a_alloc_clears_map: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ALLOC |=> row_valid_reg[slot_reg] == '0)
        else $error("bitmap rows still valid after slot allocation");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && scan_cnt_reg == SLOT_W'(SLOTS - 1) |=> state_reg == S_ALLOC)
        else $error("victim scan did not end in allocation");

    a_exec_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC && !out_free |=> state_reg == S_EXEC && $stable(slot_reg))
        else $error("request left execution while result register was busy");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == S_IDLE && !q_stat.empty)
        else $error("queue popped outside idle or while empty");
`endif

endmodule

[rtl/packet_frame_reassembly_tracker_top.sv]
// Top level of the frame reassembly slot tracker.
//
//  channel   direction  handshake              beat contents
//  in        input      in_valid / in_ready    packet header or purge request
//  out       output     out_valid / out_ready  status and pixel write command
//  cfg       input      cfg_valid / cfg_ready  register index and write data
//
// Purge, short and bad-header beats are popped and their result loaded in the same cycle
// at the queue head, once the back end is idle and the result register is free. Packets
// pass through pop, lookup, bitmap read and execute on a slot hit, with an allocate step
// before the read on a miss, after a one-slot-a-cycle scan for the oldest if all are busy.
// The bitmap is one row-wide RAM port; row valid bits clear a slot at once, no sweep.
// A 2-deep queue lets input beats land while the back end or the result register stalls.
module packet_frame_reassembly_tracker_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         req_type,
    input  logic [31:0]                  frame_id,
    input  logic [pfrt_pkg::TOTAL_W-1:0] packet_total,
    input  logic [pfrt_pkg::IDX_W-1:0]   packet_index,
    input  logic [15:0]                  raw_length,
    input  logic [15:0]                  meta_width,
    input  logic [15:0]                  meta_height,
    input  logic [31:0]                  meta_frame_bytes,
    input  logic [31:0]                  now_ms,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [3:0]                   status,
    output logic [2:0]                   slot_number,
    output logic [31:0]                  write_offset,
    output logic [15:0]                  write_length,
    output logic [15:0]                  frame_width,
    output logic [15:0]                  frame_height,
    output logic [31:0]                  frame_bytes,
    output logic [3:0]                   purged_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [15:0]                  cfg_data
);
    import pfrt_pkg::*;

    cfg_t    cfg_reg;
    item_t   push_item, head;
    q_stat_t q_stat;
    logic    push, pop;
    result_t res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms        <= TIMEOUT_RST;
            cfg_reg.header_bytes      <= HEADER_RST;
            cfg_reg.meta_bytes        <= META_RST;
            cfg_reg.max_payload_bytes <= MAX_PAYLOAD_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_TIMEOUT:     cfg_reg.timeout_ms        <= cfg_data;
                CFG_HEADER:      cfg_reg.header_bytes      <= cfg_data[7:0];
                CFG_META:        cfg_reg.meta_bytes        <= cfg_data[7:0];
                CFG_MAX_PAYLOAD: cfg_reg.max_payload_bytes <= cfg_data;
                default: ;
            endcase
        end
    end

    pfrt_front u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .req_type         (req_type),
        .frame_id         (frame_id),
        .packet_total     (packet_total),
        .packet_index     (packet_index),
        .raw_length       (raw_length),
        .meta_width       (meta_width),
        .meta_height      (meta_height),
        .meta_frame_bytes (meta_frame_bytes),
        .now_ms           (now_ms),
        .header_bytes     (cfg_reg.header_bytes),
        .q_stat           (q_stat),
        .push             (push),
        .push_item        (push_item)
    );

    pfrt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    pfrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    assign status       = res.status;
    assign slot_number  = res.slot_number;
    assign write_offset = res.write_offset;
    assign write_length = res.write_length;
    assign frame_width  = res.frame_width;
    assign frame_height = res.frame_height;
    assign frame_bytes  = res.frame_bytes;
    assign purged_count = res.purged_count;

endmodule
